### src/moe_pkg.sv
package moe_pkg;

  localparam int unsigned IdxW = 10;
  localparam int unsigned MaxIndex = 1024;

  // reciprocal scale: quotient = (q * recip) >> RecipShift is exact for q < 2**IdxW
  localparam int unsigned RecipShift = 16;
  localparam int unsigned ProdW = IdxW + RecipShift;

  localparam int unsigned PrimeW = 6;
  localparam int unsigned PsqW = 11;
  localparam int unsigned NumPrimes = 12;
  localparam int unsigned PidxW = 4;

  typedef logic signed [1:0] entry_t;
  localparam entry_t EntryZero = 2'sb00;
  localparam entry_t EntryOne = 2'sb01;
  localparam entry_t EntryNeg = 2'sb11;

  typedef struct packed {
    logic [PrimeW-1:0] prime;
    logic [PsqW-1:0] psq;
    logic [RecipShift-1:0] recip;
  } prime_t;

  // primes up to 31, then 37 whose square exceeds every quotient
  localparam prime_t PrimeTab [NumPrimes] = '{
    '{prime: 6'd2,  psq: 11'd4,    recip: 16'd32768},
    '{prime: 6'd3,  psq: 11'd9,    recip: 16'd21846},
    '{prime: 6'd5,  psq: 11'd25,   recip: 16'd13108},
    '{prime: 6'd7,  psq: 11'd49,   recip: 16'd9363},
    '{prime: 6'd11, psq: 11'd121,  recip: 16'd5958},
    '{prime: 6'd13, psq: 11'd169,  recip: 16'd5042},
    '{prime: 6'd17, psq: 11'd289,  recip: 16'd3856},
    '{prime: 6'd19, psq: 11'd361,  recip: 16'd3450},
    '{prime: 6'd23, psq: 11'd529,  recip: 16'd2850},
    '{prime: 6'd29, psq: 11'd841,  recip: 16'd2260},
    '{prime: 6'd31, psq: 11'd961,  recip: 16'd2115},
    '{prime: 6'd37, psq: 11'd1369, recip: 16'd1772}
  };

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StFetch,
    StMul,
    StTest
  } state_e;

  typedef struct packed {
    logic done;
    logic exact;
    logic [IdxW-1:0] quot;
  } div_res_t;

endpackage

### src/moebius_operator_entry.sv
// Moebius operator entry. A request (start_i high while busy_o is low) carries a row and a
// column index; the block answers with the entry of the inverse divisor-incidence matrix,
// -1, 0 or 1, on entry_value_o for the one cycle that valid_o is high. The receiver cannot
// stall: each result must be taken in the cycle it appears. Equal indices, a row above the
// column, a zero row or an index out of range answer in the cycle after the request and leave
// busy_o low. Otherwise a 10-step serial divider forms column / row to give the divisibility
// verdict; an exact quotient is then factored against a 12-entry prime table with a
// registered read, each prime tried passing through fetch, multiply and test states and
// each factor found through multiply and test again, bounded by the primes up to the
// square root of the remaining quotient.
module moebius_operator_entry (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [moe_pkg::IdxW-1:0]          row_index_i,
  input  logic [moe_pkg::IdxW-1:0]          column_index_i,
  output logic                              busy_o,
  output logic                              valid_o,
  output logic signed [1:0]                 entry_value_o
);

  localparam logic [moe_pkg::IdxW:0] MaxIdx = (moe_pkg::IdxW + 1)'(moe_pkg::MaxIndex);

  moe_pkg::state_e state_q, state_d;
  moe_pkg::div_res_t div_res;
  moe_pkg::prime_t rom_q;

  logic [moe_pkg::IdxW-1:0] q_q, q_d;
  logic [moe_pkg::PidxW-1:0] idx_q, idx_d;
  logic once_q, once_d;
  logic neg_q, neg_d;
  logic [moe_pkg::ProdW-1:0] prod_q, prod_d;
  logic valid_q, valid_d;
  moe_pkg::entry_t entry_q, entry_d;

  logic accept;
  logic special;
  moe_pkg::entry_t special_val;
  logic [moe_pkg::IdxW-1:0] part_quot;
  logic [moe_pkg::IdxW+moe_pkg::PrimeW-1:0] back;
  logic divisible;
  logic past_root;
  moe_pkg::entry_t sign_val;

  assign accept = start_i && (state_q == moe_pkg::StIdle);

  always_comb begin
    special = 1'b1;
    special_val = moe_pkg::EntryZero;
    if (row_index_i == column_index_i) begin
      special_val = moe_pkg::EntryOne;
    end else if (row_index_i > column_index_i || row_index_i == '0) begin
      special_val = moe_pkg::EntryZero;
    end else if ({1'b0, row_index_i} >= MaxIdx || {1'b0, column_index_i} >= MaxIdx) begin
      special_val = moe_pkg::EntryZero;
    end else begin
      special = 1'b0;
    end
  end

  moe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && !special),
    .dividend_i (column_index_i),
    .divisor_i  (row_index_i),
    .res_o      (div_res)
  );

  // prime table, registered read
  always_ff @(posedge clk_i) begin
    rom_q <= moe_pkg::PrimeTab[idx_q];
  end

  assign part_quot = prod_q[moe_pkg::ProdW-1:moe_pkg::RecipShift];
  assign back = (moe_pkg::IdxW + moe_pkg::PrimeW)'(part_quot) *
                (moe_pkg::IdxW + moe_pkg::PrimeW)'(rom_q.prime);
  assign divisible = (back == (moe_pkg::IdxW + moe_pkg::PrimeW)'(q_q));
  // after a factor is taken out the same prime is tried again regardless of the root bound
  assign past_root = !once_q && ({1'b0, q_q} < rom_q.psq);
  // a leftover cofactor above one is one more prime
  assign sign_val = ((q_q > (moe_pkg::IdxW)'(1)) ^ neg_q) ? moe_pkg::EntryNeg
                                                          : moe_pkg::EntryOne;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      moe_pkg::StIdle: begin
        if (accept && !special) begin
          state_d = moe_pkg::StDiv;
        end
      end
      moe_pkg::StDiv: begin
        if (div_res.done) begin
          state_d = div_res.exact ? moe_pkg::StFetch : moe_pkg::StIdle;
        end
      end
      moe_pkg::StFetch: state_d = moe_pkg::StMul;
      moe_pkg::StMul: begin
        state_d = past_root ? moe_pkg::StIdle : moe_pkg::StTest;
      end
      moe_pkg::StTest: begin
        if (divisible) begin
          state_d = once_q ? moe_pkg::StIdle : moe_pkg::StMul;
        end else begin
          state_d = moe_pkg::StFetch;
        end
      end
      default: state_d = moe_pkg::StIdle;
    endcase
  end

  // datapath and result
  always_comb begin
    q_d = q_q;
    idx_d = idx_q;
    once_d = once_q;
    neg_d = neg_q;
    prod_d = prod_q;
    valid_d = 1'b0;
    entry_d = entry_q;
    case (state_q)
      moe_pkg::StIdle: begin
        idx_d = '0;
        once_d = 1'b0;
        neg_d = 1'b0;
        if (accept && special) begin
          valid_d = 1'b1;
          entry_d = special_val;
        end
      end
      moe_pkg::StDiv: begin
        q_d = div_res.quot;
        if (div_res.done && !div_res.exact) begin
          valid_d = 1'b1;
          entry_d = moe_pkg::EntryZero;
        end
      end
      moe_pkg::StFetch: ;
      moe_pkg::StMul: begin
        prod_d = (moe_pkg::ProdW)'(q_q) * (moe_pkg::ProdW)'(rom_q.recip);
        if (past_root) begin
          valid_d = 1'b1;
          entry_d = sign_val;
        end
      end
      moe_pkg::StTest: begin
        if (divisible) begin
          if (once_q) begin
            valid_d = 1'b1;
            entry_d = moe_pkg::EntryZero;
          end else begin
            q_d = part_quot;
            once_d = 1'b1;
            neg_d = !neg_q;
          end
        end else begin
          once_d = 1'b0;
          idx_d = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= moe_pkg::StIdle;
      valid_q <= 1'b0;
      idx_q <= '0;
      once_q <= 1'b0;
      neg_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q <= idx_d;
      once_q <= once_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    prod_q <= prod_d;
    entry_q <= entry_d;
  end

  assign busy_o = (state_q != moe_pkg::StIdle);
  assign valid_o = valid_q;
  assign entry_value_o = entry_q;

  a_entry_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (entry_value_o != 2'sb10))
    else $error("entry code out of range");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result while a request is still in work");

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> valid_o)
    else $error("request finished without a result");

  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && special) |=> (valid_o && !busy_o))
    else $error("trivial request not answered in one cycle");

endmodule

### src/moe_div.sv
module moe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [moe_pkg::IdxW-1:0]   dividend_i,
  input  logic [moe_pkg::IdxW-1:0]   divisor_i,
  output moe_pkg::div_res_t          res_o
);

  localparam int unsigned CntW = $clog2(moe_pkg::IdxW);
  localparam logic [CntW-1:0] CntLast = CntW'(moe_pkg::IdxW - 1);

  logic run_q, run_d;
  logic done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [moe_pkg::IdxW-1:0] rem_q, rem_d;
  logic [moe_pkg::IdxW-1:0] quot_q, quot_d;
  logic [moe_pkg::IdxW-1:0] dvs_q, dvs_d;
  logic [moe_pkg::IdxW:0] shifted;
  logic [moe_pkg::IdxW:0] trial;

  assign shifted = {rem_q, quot_q[moe_pkg::IdxW-1]};
  assign trial = shifted - {1'b0, dvs_q};

  always_comb begin
    run_d = run_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quot_d = quot_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quot_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      // one restoring step per cycle
      if (!trial[moe_pkg::IdxW]) begin
        rem_d = trial[moe_pkg::IdxW-1:0];
        quot_d = {quot_q[moe_pkg::IdxW-2:0], 1'b1};
      end else begin
        rem_d = shifted[moe_pkg::IdxW-1:0];
        quot_d = {quot_q[moe_pkg::IdxW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quot_q <= quot_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.exact = (rem_q == '0);
  assign res_o.quot = quot_q;

endmodule
